[rtl/buddy_page_allocator_core_assert.svh]
// assertion macros for the buddy page allocator
`ifndef BUDDY_PAGE_ALLOCATOR_CORE_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_CORE_ASSERT_SVH
// property that holds from each clock edge outside reset
`define BPA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// property that must hold during reset as well
`define BPA_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);
`endif

[rtl/bpa_pkg.sv]
// package of types, constants and codes for the buddy page allocator
package bpa_pkg;
   localparam int TOP_ORDER = 10;
   localparam int ZONE_PAGES_MAX = 65536;
   localparam int PAGE_NUMBER_BITS = 36;
   localparam int OFF_W = $clog2(ZONE_PAGES_MAX);
   localparam int CNT_W = 17;
   localparam int ORD_W = 5;
   localparam int LVL_W = $clog2(TOP_ORDER + 1);
   localparam int NUM_LISTS = TOP_ORDER + 1;
   localparam logic [CNT_W-1:0] COUNT_MAX = '1;
   localparam int REG_BASE = 0;
   localparam int REG_COUNT = 1;

   typedef logic [PAGE_NUMBER_BITS-1:0] page_type;
   typedef logic [OFF_W-1:0] off_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE = 2'd1,
      OP_REBUILD = 2'd2,
      OP_NOP = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0,
      ST_OOM = 3'd1,
      ST_BAD_ORDER = 3'd2,
      ST_NULL = 3'd3,
      ST_UNALIGNED = 3'd4,
      ST_OUTSIDE = 3'd5
   } status_type;

   typedef struct packed {
      logic [1:0] op;
      logic [ORD_W-1:0] block_order;
      page_type block_page;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      page_type granted_page;
      cnt_type free_page_total;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_RB_BIG,
      S_RB_TAIL,
      S_AL_SCAN,
      S_AL_POP,
      S_AL_SPLIT,
      S_FR_CHECK,
      S_FR_MERGE,
      S_FR_WALK,
      S_FR_HIT,
      S_FR_PUSH,
      S_DONE
   } state_type;

   // link memory port request
   typedef struct packed {
      logic we;
      off_type addr;
      off_type wdata;
   } mem_req_type;
endpackage

[rtl/bpa_link_ram.sv]
// link memory: one next-offset per page offset, registered read
module bpa_link_ram (
   input logic clock,
   input bpa_pkg::mem_req_type mreq,
   output bpa_pkg::off_type rdata
);
   bpa_pkg::off_type mem [bpa_pkg::ZONE_PAGES_MAX];
   bpa_pkg::off_type rdata_ff;

   always_ff @(posedge clock) begin
      if (mreq.we) begin
         mem[mreq.addr] <= mreq.wdata;
      end
      rdata_ff <= mem[mreq.addr];
   end

   assign rdata = rdata_ff;
endmodule

[rtl/bpa_ctrl.sv]
// sequencer for rebuild, allocate and free over the link memory
module bpa_ctrl (
   input logic clock,
   input logic reset,
   input logic start,
   input bpa_pkg::req_type req,
   input bpa_pkg::page_type base,
   input logic [bpa_pkg::CNT_W-1:0] zcount,
   output bpa_pkg::mem_req_type mreq,
   input bpa_pkg::off_type mrdata,
   output logic done,
   output bpa_pkg::rsp_type rsp
);
   localparam int PW = bpa_pkg::PAGE_NUMBER_BITS;
   localparam int XW = bpa_pkg::PAGE_NUMBER_BITS + 1;
   localparam int OW = bpa_pkg::OFF_W;
   localparam int CW = bpa_pkg::CNT_W;
   localparam int LW = bpa_pkg::LVL_W;
   localparam logic [XW-1:0] BIG = XW'(1) << bpa_pkg::TOP_ORDER;

   bpa_pkg::state_type state_ff, state_in;
   bpa_pkg::off_type head_ff [bpa_pkg::NUM_LISTS];
   bpa_pkg::cnt_type cnt_ff [bpa_pkg::NUM_LISTS];
   bpa_pkg::cnt_type total_ff, total_in;
   logic [XW-1:0] a_ff, a_in, end_ff, end_in;
   logic [PW-1:0] page_ff, page_in;
   logic [LW-1:0] lvl_ff, lvl_in, ord_ff, ord_in;
   bpa_pkg::cnt_type k_ff, k_in;
   bpa_pkg::off_type cur_ff, cur_in, prev_ff, prev_in, tgt_ff, tgt_in;
   logic [2:0] status_ff, status_in;
   logic [PW-1:0] grant_ff, grant_in;
   logic [bpa_pkg::ORD_W-1:0] rord_ff, rord_in;
   logic [1:0] op_ff, op_in;

   // list update controls
   logic push_en, pop_set, dec_en, clr_all;
   logic [LW-1:0] l_sel;
   bpa_pkg::off_type push_off, pop_head;
   logic [XW-1:0] zpages, zend, push_page, a_al;
   logic [PW-1:0] bud;
   logic [CW-1:0] sub_amt, add_amt;
   logic sub_en, add_en;

   // zone end and alignment carry one bit above the page number
   always_comb begin
      zpages = (zcount > CW'(bpa_pkg::ZONE_PAGES_MAX))
         ? XW'(bpa_pkg::ZONE_PAGES_MAX) : XW'(zcount);
      zend = XW'(base) + zpages;
      a_al = (XW'(base) + BIG - XW'(1)) & ~(BIG - XW'(1));
      bud = page_ff ^ (PW'(1) << ord_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpa_pkg::S_IDLE;
         total_ff <= '0;
         for (int i = 0; i < bpa_pkg::NUM_LISTS; i++) begin
            head_ff[i] <= '0;
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         if (clr_all) begin
            for (int i = 0; i < bpa_pkg::NUM_LISTS; i++) begin
               head_ff[i] <= '0;
               cnt_ff[i] <= '0;
            end
         end else if (push_en) begin
            if (cnt_ff[l_sel] != bpa_pkg::COUNT_MAX) begin
               head_ff[l_sel] <= push_off;
               cnt_ff[l_sel] <= cnt_ff[l_sel] + CW'(1);
            end
         end else begin
            if (pop_set) begin
               head_ff[l_sel] <= pop_head;
            end
            if (dec_en) begin
               cnt_ff[l_sel] <= cnt_ff[l_sel] - CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      end_ff <= end_in;
      page_ff <= page_in;
      lvl_ff <= lvl_in;
      ord_ff <= ord_in;
      k_ff <= k_in;
      cur_ff <= cur_in;
      prev_ff <= prev_in;
      tgt_ff <= tgt_in;
      status_ff <= status_in;
      grant_ff <= grant_in;
      rord_ff <= rord_in;
      op_ff <= op_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bpa_pkg::S_IDLE: if (start) state_in = bpa_pkg::S_DECODE;
         bpa_pkg::S_DECODE: begin
            case (bpa_pkg::op_type'(op_ff))
               bpa_pkg::OP_ALLOC:
                  state_in = (rord_ff > bpa_pkg::ORD_W'(bpa_pkg::TOP_ORDER))
                     ? bpa_pkg::S_DONE : bpa_pkg::S_AL_SCAN;
               bpa_pkg::OP_FREE: state_in = bpa_pkg::S_FR_CHECK;
               bpa_pkg::OP_REBUILD: state_in = bpa_pkg::S_RB_BIG;
               default: state_in = bpa_pkg::S_DONE;
            endcase
         end
         bpa_pkg::S_RB_BIG:
            if (!(a_ff + BIG <= end_ff)) state_in = bpa_pkg::S_RB_TAIL;
         bpa_pkg::S_RB_TAIL: begin
            if (!(a_ff < end_ff && end_ff - a_ff >= (XW'(1) << lvl_ff)
                  && (a_ff & ((XW'(1) << lvl_ff) - XW'(1))) == '0)
                  && lvl_ff == '0) begin
               state_in = bpa_pkg::S_DONE;
            end
         end
         bpa_pkg::S_AL_SCAN: begin
            if (cnt_ff[lvl_ff] != '0) state_in = bpa_pkg::S_AL_POP;
            else if (lvl_ff == LW'(bpa_pkg::TOP_ORDER)) state_in = bpa_pkg::S_DONE;
         end
         bpa_pkg::S_AL_POP: state_in = bpa_pkg::S_AL_SPLIT;
         bpa_pkg::S_AL_SPLIT:
            if (lvl_ff == ord_ff) state_in = bpa_pkg::S_DONE;
         bpa_pkg::S_FR_CHECK:
            state_in = (status_in == bpa_pkg::ST_OK)
               ? bpa_pkg::S_FR_MERGE : bpa_pkg::S_DONE;
         bpa_pkg::S_FR_MERGE: begin
            if (ord_ff == LW'(bpa_pkg::TOP_ORDER) || bud < base
                  || XW'(bud) >= zend) state_in = bpa_pkg::S_FR_PUSH;
            else state_in = bpa_pkg::S_FR_WALK;
         end
         bpa_pkg::S_FR_WALK: begin
            if (k_ff >= cnt_ff[ord_ff]) state_in = bpa_pkg::S_FR_PUSH;
            else if (cur_ff == tgt_ff) state_in = bpa_pkg::S_FR_HIT;
         end
         bpa_pkg::S_FR_HIT: state_in = bpa_pkg::S_FR_MERGE;
         bpa_pkg::S_FR_PUSH: state_in = bpa_pkg::S_DONE;
         bpa_pkg::S_DONE: state_in = bpa_pkg::S_IDLE;
         default: state_in = bpa_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      a_in = a_ff;
      end_in = end_ff;
      page_in = page_ff;
      lvl_in = lvl_ff;
      ord_in = ord_ff;
      k_in = k_ff;
      cur_in = cur_ff;
      prev_in = prev_ff;
      tgt_in = tgt_ff;
      status_in = status_ff;
      grant_in = grant_ff;
      rord_in = rord_ff;
      op_in = op_ff;
      total_in = total_ff;
      push_en = 1'b0;
      pop_set = 1'b0;
      dec_en = 1'b0;
      clr_all = 1'b0;
      l_sel = lvl_ff;
      push_page = a_ff;
      pop_head = mrdata;
      sub_en = 1'b0;
      add_en = 1'b0;
      sub_amt = '0;
      add_amt = '0;
      mreq = '0;
      done = 1'b0;
      case (state_ff)
         bpa_pkg::S_IDLE: begin
            if (start) begin
               op_in = req.op;
               rord_in = req.block_order;
               page_in = req.block_page;
               status_in = bpa_pkg::ST_OK;
               grant_in = '0;
               ord_in = LW'(req.block_order);
               lvl_in = LW'(req.block_order);
            end
         end
         bpa_pkg::S_DECODE: begin
            if (op_ff == bpa_pkg::OP_ALLOC
                  && rord_ff > bpa_pkg::ORD_W'(bpa_pkg::TOP_ORDER)) begin
               status_in = bpa_pkg::ST_BAD_ORDER;
            end
            if (op_ff == bpa_pkg::OP_REBUILD) begin
               clr_all = 1'b1;
               total_in = '0;
               a_in = a_al;
               end_in = zend;
               lvl_in = LW'(bpa_pkg::TOP_ORDER);
            end
         end
         bpa_pkg::S_RB_BIG: begin
            if (a_ff + BIG <= end_ff) begin
               l_sel = LW'(bpa_pkg::TOP_ORDER);
               push_page = a_ff;
               push_en = 1'b1;
               add_en = 1'b1;
               add_amt = CW'(BIG);
               a_in = a_ff + BIG;
            end
         end
         bpa_pkg::S_RB_TAIL: begin
            if (a_ff < end_ff && end_ff - a_ff >= (XW'(1) << lvl_ff)
                  && (a_ff & ((XW'(1) << lvl_ff) - XW'(1))) == '0) begin
               push_page = a_ff;
               push_en = 1'b1;
               add_en = 1'b1;
               add_amt = CW'(XW'(1) << lvl_ff);
               a_in = a_ff + (XW'(1) << lvl_ff);
            end else if (lvl_ff != '0) begin
               lvl_in = lvl_ff - LW'(1);
            end
         end
         bpa_pkg::S_AL_SCAN: begin
            if (cnt_ff[lvl_ff] != '0) begin
               mreq.addr = head_ff[lvl_ff];
               grant_in = base + PW'(head_ff[lvl_ff]);
            end else if (lvl_ff == LW'(bpa_pkg::TOP_ORDER)) begin
               status_in = bpa_pkg::ST_OOM;
            end else begin
               lvl_in = lvl_ff + LW'(1);
            end
         end
         bpa_pkg::S_AL_POP: begin
            pop_set = 1'b1;
            dec_en = 1'b1;
            pop_head = mrdata;
         end
         bpa_pkg::S_AL_SPLIT: begin
            if (lvl_ff != ord_ff) begin
               l_sel = lvl_ff - LW'(1);
               push_page = XW'(grant_ff) + (XW'(1) << (lvl_ff - LW'(1)));
               push_en = 1'b1;
               lvl_in = lvl_ff - LW'(1);
            end else begin
               sub_en = 1'b1;
               sub_amt = CW'(1) << ord_ff;
            end
         end
         bpa_pkg::S_FR_CHECK: begin
            if (page_ff == '0) status_in = bpa_pkg::ST_NULL;
            else if (rord_ff > bpa_pkg::ORD_W'(bpa_pkg::TOP_ORDER))
               status_in = bpa_pkg::ST_BAD_ORDER;
            else if ((page_ff & ((PW'(1) << ord_ff) - PW'(1))) != '0)
               status_in = bpa_pkg::ST_UNALIGNED;
            else if (page_ff < base || XW'(page_ff) >= zend)
               status_in = bpa_pkg::ST_OUTSIDE;
         end
         bpa_pkg::S_FR_MERGE: begin
            tgt_in = OW'(bud - base);
            cur_in = head_ff[ord_ff];
            k_in = '0;
            mreq.addr = head_ff[ord_ff];
         end
         bpa_pkg::S_FR_WALK: begin
            l_sel = ord_ff;
            if (k_ff < cnt_ff[ord_ff]) begin
               if (cur_ff == tgt_ff) begin
                  // mrdata is next of cur
                  if (k_ff == '0) begin
                     pop_set = 1'b1;
                     pop_head = mrdata;
                  end else begin
                     mreq.we = 1'b1;
                     mreq.addr = prev_ff;
                     mreq.wdata = mrdata;
                  end
                  dec_en = 1'b1;
                  sub_en = 1'b1;
                  sub_amt = CW'(1) << ord_ff;
               end else begin
                  prev_in = cur_ff;
                  cur_in = mrdata;
                  k_in = k_ff + CW'(1);
                  mreq.addr = mrdata;
               end
            end
         end
         bpa_pkg::S_FR_HIT: begin
            if (bud < page_ff) page_in = bud;
            ord_in = ord_ff + LW'(1);
         end
         bpa_pkg::S_FR_PUSH: begin
            l_sel = ord_ff;
            push_page = XW'(page_ff);
            push_en = 1'b1;
            add_en = 1'b1;
            add_amt = CW'(1) << ord_ff;
         end
         bpa_pkg::S_DONE: begin
            done = 1'b1;
         end
         default: ;
      endcase
      push_off = OW'(push_page - XW'(base));
      if (push_en && cnt_ff[l_sel] != bpa_pkg::COUNT_MAX) begin
         mreq.we = 1'b1;
         mreq.addr = push_off;
         mreq.wdata = head_ff[l_sel];
      end
      if (add_en) begin
         total_in = ({1'b0, total_ff} + {1'b0, add_amt} > {1'b0, bpa_pkg::COUNT_MAX})
            ? bpa_pkg::COUNT_MAX : total_ff + add_amt;
      end
      if (sub_en) begin
         total_in = (total_ff < sub_amt) ? '0 : total_ff - sub_amt;
      end
      rsp.status = status_ff;
      rsp.granted_page = (status_ff == bpa_pkg::ST_OK) ? grant_ff : '0;
      rsp.free_page_total = total_ff;
   end
endmodule

[rtl/buddy_page_allocator_core.sv]
// top level of the buddy page allocator
// binary buddy allocator over a zone of page numbers
// req channel: op, block_order, block_page; one rsp transaction per req
// transaction carrying status, granted page and free page total
// csr port, 64-bit data: zone_base_page at 0x0, zone_page_count at 0x8;
// the user writes them only while idle, which the block does not enforce;
// reads return the stored values
// no operation, allocate with a bad order and a rejected free go straight
// to the rsp; allocate scans upward from the order asked for, pops a block
// and splits it down to that order, or reports out of memory at the top
// order; free merges each buddy found in its list, walked at one link
// memory read per element; rebuild pushes top order blocks, then the tail
// one transaction at a time, set by the single port of the link memory;
// the next req is taken only after the rsp has been taken
// reset empties all lists and zeroes counts; the link memory is not cleared
// a finished rsp waits in its output register while rsp_stall is high and
// req_stall stays high until it has been taken
module buddy_page_allocator_core (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input bpa_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output bpa_pkg::rsp_type rsp_data,
   input logic psel,
   input logic penable,
   input logic pwrite,
   input logic [3:0] paddr,
   input logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic pready
);
   bpa_pkg::page_type base_ff;
   bpa_pkg::cnt_type zcount_ff;
   logic busy_ff, busy_in, rsp_valid_ff, rsp_valid_in, start, done;
   logic hi_sel;
   bpa_pkg::rsp_type rsp_ff, rsp_in, ctrl_rsp;
   bpa_pkg::mem_req_type mreq;
   bpa_pkg::off_type mrdata;

   assign pready = 1'b1;
   assign hi_sel = paddr[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         zcount_ff <= '0;
      end else if (psel && penable && pwrite) begin
         if (paddr == 4'(8 * bpa_pkg::REG_BASE)) begin
            base_ff <= pwdata[bpa_pkg::PAGE_NUMBER_BITS-1:0];
         end else if (paddr == 4'(8 * bpa_pkg::REG_COUNT)) begin
            zcount_ff <= pwdata[bpa_pkg::CNT_W-1:0];
         end
      end
   end

   always_comb begin
      prdata = '0;
      if (hi_sel) prdata = 64'(zcount_ff);
      else prdata = 64'(base_ff);
   end

   assign req_stall = busy_ff || rsp_valid_ff;
   assign start = req_valid && !req_stall;

   always_comb begin
      busy_in = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (start) busy_in = 1'b1;
      if (done) begin
         busy_in = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_in = ctrl_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   bpa_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req(req_data),
      .base(base_ff),
      .zcount(zcount_ff),
      .mreq(mreq),
      .mrdata(mrdata),
      .done(done),
      .rsp(ctrl_rsp)
   );

   bpa_link_ram u_ram (
      .clock(clock),
      .mreq(mreq),
      .rdata(mrdata)
   );
endmodule

[rtl/bpa_checker.sv]
// port-level assertion checker for the buddy page allocator
`include "buddy_page_allocator_core_assert.svh"
module bpa_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input bpa_pkg::rsp_type rsp_data
);
   `BPA_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "rsp moved")
   `BPA_ASSERT(a_busy_stall, rsp_valid |-> req_stall, "req taken with rsp pending")
   `BPA_ASSERT(a_status_range, rsp_valid |-> rsp_data.status <= bpa_pkg::ST_OUTSIDE, "bad status")
   `BPA_ASSERT(a_one_rsp, req_valid && !req_stall |=> !rsp_valid, "rsp too early")
   `BPA_ASSERT_RST(a_reset, reset |=> !rsp_valid, "rsp valid after reset")
endmodule

bind buddy_page_allocator_core bpa_checker u_chk (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data(rsp_data)
);
